@@ rtl/core/counter_priority_task_scheduler_top_assert.svh @@
// assertion macros for the task scheduler
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_TOP_ASSERT_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CTPS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctps check failed");
`define CTPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctps check failed");
`else
`define CTPS_ASSERT_SAME(lbl, ante, cons)
`define CTPS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/ctps_pkg.sv @@
`default_nettype none
package ctps_pkg;

    localparam int TASK_SLOTS = 64;
    localparam int IDX_W      = $clog2(TASK_SLOTS);

    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_TICK  = 3'd1,
        CMD_SCHED = 3'd2,
        CMD_PAUSE = 3'd3,
        CMD_WAKE  = 3'd4
    } cmd_t;

    localparam logic [1:0]  RS_RUNNING = 2'd0;
    localparam logic [1:0]  RS_INTR    = 2'd1;
    localparam logic [31:0] ALARM_SIG  = 32'h1 << 13;
    localparam logic [7:0]  IDLE_SLICE = 8'd15;

    typedef struct packed {
        logic        present;
        logic [1:0]  run_state;
        logic [7:0]  counter;
        logic [6:0]  prio;
        logic [31:0] alarm;
        logic [31:0] sig;
    } entry_t;

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
    } mem_req_t;

    function automatic entry_t reset_entry(logic [IDX_W-1:0] idx);
        entry_t e;
        e = '0;
        if (idx == '0)
        begin
            e.present = 1'b1;
            e.counter = IDLE_SLICE;
            e.prio    = 7'(IDLE_SLICE);
        end
        else
        begin
            e.prio = 7'd1;
        end
        return e;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/ctps_if.sv @@
`default_nettype none
interface ctps_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [5:0]  slot;
    logic        present;
    logic [1:0]  run_state;
    logic [7:0]  counter_value;
    logic [6:0]  priority_value;
    logic [31:0] alarm_value;
    logic [31:0] signal_value;
    logic        in_user;
    logic [31:0] now_ticks;

    modport source (output valid, command, slot, present, run_state, counter_value,
                    priority_value, alarm_value, signal_value, in_user, now_ticks,
                    input ready);
    modport sink (input valid, command, slot, present, run_state, counter_value,
                  priority_value, alarm_value, signal_value, in_user, now_ticks,
                  output ready);
endinterface

interface ctps_rsp_if;
    logic       valid;
    logic       ready;
    logic [5:0] current_task;
    logic       switched;
    logic [7:0] current_counter;
    logic       error;

    modport source (output valid, current_task, switched, current_counter, error,
                    input ready);
    modport sink (input valid, current_task, switched, current_counter, error,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/core/ctps_mem.sv @@
`default_nettype none
module ctps_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  ctps_pkg::mem_req_t req,
    output ctps_pkg::entry_t   rdata
);
    import ctps_pkg::*;

    entry_t            task_mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] valid_reg;
    entry_t            rd_reg;
    logic              rd_valid_reg;
    logic [IDX_W-1:0]  rd_addr_reg;

    // task table, one read and one write port
    always_ff @(posedge clk)
    begin
        if (req.we)
            task_mem[req.waddr] <= req.wdata;
        if (req.re)
            rd_reg <= task_mem[req.raddr];
    end

    // entries never written read as their reset contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_addr_reg  <= '0;
        end
        else
        begin
            if (req.we)
                valid_reg[req.waddr] <= 1'b1;
            if (req.re)
            begin
                rd_valid_reg <= valid_reg[req.raddr];
                rd_addr_reg  <= req.raddr;
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_reg : reset_entry(rd_addr_reg);

endmodule
`default_nettype wire

@@ rtl/core/ctps_ctrl.sv @@
`default_nettype none
module ctps_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    ctps_req_if.sink           req,
    ctps_rsp_if.source         rsp,
    output ctps_pkg::mem_req_t mem_req,
    input  ctps_pkg::entry_t   rdata
);
    import ctps_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_MOD, ST_ALM_RD, ST_ALM_WR, ST_PICK_RD, ST_PICK_EV,
        ST_AGE_RD, ST_AGE_WR, ST_RDCUR, ST_RDOUT, ST_OUT
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);
    localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

    state_t           state_reg;
    cmd_t             cmd_reg;
    logic [IDX_W-1:0] slot_reg;
    logic             present_reg;
    logic [1:0]       run_state_reg;
    logic [7:0]       counter_reg;
    logic [6:0]       prio_reg;
    logic [31:0]      alarm_reg;
    logic [31:0]      signal_reg;
    logic             in_user_reg;
    logic [31:0]      now_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] cur_reg;
    logic [IDX_W-1:0] pick_reg;
    logic             found_reg;
    logic [7:0]       best_reg;
    logic             switched_reg;
    logic             err_reg;
    logic [7:0]       cur_cnt_reg;
    logic             out_valid_reg;
    logic [5:0]       out_task_reg;
    logic             out_switched_reg;
    logic [7:0]       out_counter_reg;
    logic             out_error_reg;

    entry_t     alarm_upd;
    entry_t     aged;
    logic [8:0] age_sum;
    logic       pick_hit;

    // alarm step for one slot
    always_comb
    begin
        alarm_upd = rdata;
        if (rdata.alarm != '0 && rdata.alarm < now_reg)
        begin
            alarm_upd.sig   = rdata.sig | ALARM_SIG;
            alarm_upd.alarm = '0;
        end
        if (alarm_upd.sig != '0 && rdata.run_state == RS_INTR)
            alarm_upd.run_state = RS_RUNNING;
    end

    // counter aging: counter/2 plus priority, saturated
    always_comb
    begin
        aged    = rdata;
        age_sum = {2'b00, rdata.counter[7:1]} + {2'b00, rdata.prio};
        aged.counter = age_sum[8] ? 8'hFF : age_sum[7:0];
    end

    assign pick_hit = rdata.present && rdata.run_state == RS_RUNNING &&
                      (!found_reg || rdata.counter > best_reg);

    always_comb
    begin
        mem_req = '0;
        unique case (state_reg)
            ST_DISPATCH:
            begin
                unique case (cmd_reg)
                    CMD_WRITE:
                    begin
                        mem_req.we              = 1'b1;
                        mem_req.waddr           = slot_reg;
                        mem_req.wdata.present   = present_reg;
                        mem_req.wdata.run_state = run_state_reg;
                        mem_req.wdata.counter   = counter_reg;
                        mem_req.wdata.prio      = (prio_reg == '0) ? 7'd1 : prio_reg;
                        mem_req.wdata.alarm     = alarm_reg;
                        mem_req.wdata.sig       = signal_reg;
                    end
                    CMD_TICK, CMD_PAUSE:
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = cur_reg;
                    end
                    CMD_WAKE:
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = slot_reg;
                    end
                    default: ;
                endcase
            end
            ST_MOD:
            begin
                mem_req.wdata = rdata;
                unique case (cmd_reg)
                    CMD_WAKE:
                    begin
                        mem_req.we                = rdata.present;
                        mem_req.waddr             = slot_reg;
                        mem_req.wdata.run_state   = RS_RUNNING;
                    end
                    CMD_TICK:
                    begin
                        mem_req.we            = 1'b1;
                        mem_req.waddr         = cur_reg;
                        mem_req.wdata.counter = (rdata.counter > 8'd1) ?
                                                rdata.counter - 8'd1 : 8'd0;
                    end
                    CMD_PAUSE:
                    begin
                        mem_req.we              = 1'b1;
                        mem_req.waddr           = cur_reg;
                        mem_req.wdata.run_state = RS_INTR;
                    end
                    default: ;
                endcase
            end
            ST_ALM_RD, ST_PICK_RD, ST_AGE_RD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = idx_reg;
            end
            ST_ALM_WR:
            begin
                mem_req.we    = rdata.present;
                mem_req.waddr = idx_reg;
                mem_req.wdata = alarm_upd;
            end
            ST_AGE_WR:
            begin
                mem_req.we    = rdata.present;
                mem_req.waddr = idx_reg;
                mem_req.wdata = aged;
            end
            ST_RDCUR:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = cur_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= CMD_SCHED;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            switched_reg  <= 1'b0;
            err_reg       <= 1'b0;
        end
        else
        begin
            if (rsp.ready && state_reg != ST_OUT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        cmd_reg        <= cmd_t'(req.command);
                        slot_reg       <= IDX_W'(req.slot);
                        present_reg    <= req.present;
                        run_state_reg  <= req.run_state;
                        counter_reg    <= req.counter_value;
                        prio_reg       <= req.priority_value;
                        alarm_reg      <= req.alarm_value;
                        signal_reg     <= req.signal_value;
                        in_user_reg    <= req.in_user;
                        now_reg        <= req.now_ticks;
                        switched_reg   <= 1'b0;
                        err_reg        <= 1'b0;
                        state_reg      <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH:
                begin
                    idx_reg <= LAST_IDX;
                    unique case (cmd_reg)
                        CMD_TICK, CMD_PAUSE, CMD_WAKE: state_reg <= ST_MOD;
                        CMD_SCHED:
                        begin
                            switched_reg <= 1'b1;
                            state_reg    <= ST_ALM_RD;
                        end
                        default: state_reg <= ST_RDCUR;
                    endcase
                end
                ST_MOD:
                begin
                    state_reg <= ST_RDCUR;
                    unique case (cmd_reg)
                        CMD_WAKE: err_reg <= !rdata.present;
                        CMD_TICK:
                        begin
                            if (rdata.counter <= 8'd1 && in_user_reg)
                            begin
                                switched_reg <= 1'b1;
                                state_reg    <= ST_ALM_RD;
                            end
                        end
                        CMD_PAUSE:
                        begin
                            switched_reg <= 1'b1;
                            state_reg    <= ST_ALM_RD;
                        end
                        default: ;
                    endcase
                end
                ST_ALM_RD: state_reg <= ST_ALM_WR;
                ST_ALM_WR:
                begin
                    if (idx_reg == FIRST_IDX)
                    begin
                        idx_reg   <= LAST_IDX;
                        found_reg <= 1'b0;
                        pick_reg  <= '0;
                        state_reg <= ST_PICK_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= ST_ALM_RD;
                    end
                end
                ST_PICK_RD: state_reg <= ST_PICK_EV;
                ST_PICK_EV:
                begin
                    if (idx_reg == FIRST_IDX)
                    begin
                        idx_reg <= LAST_IDX;
                        if (pick_hit ? (rdata.counter == '0)
                                     : (found_reg && best_reg == '0))
                            state_reg <= ST_AGE_RD;
                        else
                        begin
                            cur_reg   <= pick_hit ? idx_reg : pick_reg;
                            state_reg <= ST_RDCUR;
                        end
                    end
                    else
                    begin
                        if (pick_hit)
                        begin
                            found_reg <= 1'b1;
                            best_reg  <= rdata.counter;
                            pick_reg  <= idx_reg;
                        end
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= ST_PICK_RD;
                    end
                end
                ST_AGE_RD: state_reg <= ST_AGE_WR;
                ST_AGE_WR:
                begin
                    if (idx_reg == FIRST_IDX)
                    begin
                        idx_reg   <= LAST_IDX;
                        found_reg <= 1'b0;
                        pick_reg  <= '0;
                        state_reg <= ST_PICK_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= ST_AGE_RD;
                    end
                end
                ST_RDCUR: state_reg <= ST_RDOUT;
                ST_RDOUT:
                begin
                    cur_cnt_reg <= rdata.counter;
                    state_reg   <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_task_reg     <= 6'(cur_reg);
                        out_switched_reg <= switched_reg;
                        out_counter_reg  <= cur_cnt_reg;
                        out_error_reg    <= err_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign req.ready           = (state_reg == ST_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.current_task    = out_task_reg;
    assign rsp.switched        = out_switched_reg;
    assign rsp.current_counter = out_counter_reg;
    assign rsp.error           = out_error_reg;

endmodule
`default_nettype wire

@@ rtl/core/counter_priority_task_scheduler_top.sv @@
// a scheduling pass walks slots 63 down to 1 for alarms, then again for the pick,
// plus an aging sweep and a new pick whenever the best counter found is zero
// throughput: one word at a time; a new word is taken only while the sequencer is idle
// reset: asynchronous active low; task table reads as its reset contents until written
`default_nettype none
`include "counter_priority_task_scheduler_top_assert.svh"
module counter_priority_task_scheduler_top (
    input  logic       clk,
    input  logic       rst_n,
    ctps_req_if.sink   task_req,
    ctps_rsp_if.source task_rsp
);
    import ctps_pkg::*;

    // request from the sequencer to the task table
    mem_req_t mem_req;
    // registered read word of the task table
    entry_t   rdata;

    // sequencer: command decode, alarm/pick/aging sweeps, result register
    ctps_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (task_req),
        .rsp     (task_rsp),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    // task slot table with per-entry written flags
    ctps_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (rdata)
    );

    // no table write while waiting for a new word
    `CTPS_ASSERT_SAME(a_idle_no_write, task_req.ready, !mem_req.we)
    // read and write never hit the same entry in one cycle
    `CTPS_ASSERT_SAME(a_no_rw_clash, mem_req.re && mem_req.we, mem_req.raddr != mem_req.waddr)
    // one word in flight at a time
    `CTPS_ASSERT_NEXT(a_one_in_flight, task_req.valid && task_req.ready, !task_req.ready)

endmodule
`default_nettype wire
